>>> hdl/nlt_pkg.sv
// Package: types and constants for the neighbour liveness table.
package nlt_pkg;

    localparam int MAX_PEERS = 16;
    localparam int SLOT_W    = $clog2(MAX_PEERS);
    localparam int CNT_W     = $clog2(MAX_PEERS + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_MAC     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_TIMEOUT = 1'd1;

    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_ACTIVE  = 2'd1;
    localparam logic [1:0] ST_LOST    = 2'd2;
    localparam logic [1:0] ST_SLEEP   = 2'd3;

    localparam logic [2:0] PT_HEARTBEAT = 3'd0;
    localparam logic [2:0] PT_DISCOVERY = 3'd1;
    localparam logic [2:0] PT_SLEEP     = 3'd4;
    localparam logic [2:0] PT_WAKE      = 3'd5;

    localparam logic [2:0] EV_UPDATED = 3'd0;
    localparam logic [2:0] EV_JOINED  = 3'd1;
    localparam logic [2:0] EV_FULL    = 3'd2;
    localparam logic [2:0] EV_OWN     = 3'd3;
    localparam logic [2:0] EV_LOST    = 3'd4;
    localparam logic [2:0] EV_DONE    = 3'd5;

    typedef struct packed {
        logic        mode;
        logic [31:0] now_ms;
        logic [47:0] src_mac;
        logic [47:0] sender_mac;
        logic [2:0]  packet_type;
        logic        payload_ok;
        logic signed [7:0] rssi;
        logic [7:0]  reported_neighbours;
    } item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  slot;
        logic [47:0] node_mac;
        logic [4:0]  active_count;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_SWEEP,
        S_DONE
    } state_t;

endpackage

>>> hdl/neighbour_liveness_table.sv
// Top level: neighbour liveness table with memory-held entries and a scanning sequencer.
//
// Usage: pulse start with one word on item while busy is low. Mode 0 is a
// received packet, mode 1 a loss sweep. Results appear on result for one
// cycle each, marked by result_valid; result.last closes an item's results.
// The receiver cannot stall; results are never held back.
// Configuration: cfg_we, cfg_index, cfg_data, written while idle.
// Operation: the entry memory is read one entry a cycle through a registered
// read port. A packet scans the stored entries until it finds its source or
// passes the entry count, then ends in the write state, which writes the
// entry back or reports a full table; busy is high through scan and write.
// An own packet is answered through the result register and never raises
// busy. A sweep reads every stored entry once, writing lost ones back in the
// same pass, with one result per lost peer plus the closing summary word.
// The active count is kept in a register beside the memory and adjusted on
// every status change, so it never needs a separate scan.
// Reset clears the entry count, the active count and the sequencer; the
// memory contents are undefined and are only used below the entry count.
module neighbour_liveness_table
    import nlt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  item_t         item,
    output logic          result_valid,
    output result_t       result,
    input  logic          cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]   cfg_data
);

    localparam int ENT_W = 48 + 2 + 32 + 8 + 8;

    typedef struct packed {
        logic [47:0] mac;
        logic [1:0]  status;
        logic [31:0] seen;
        logic [7:0]  rssi;
        logic [7:0]  rep;
    } entry_t;

    entry_t mem [MAX_PEERS];
    entry_t rd_reg;

    logic [47:0] self_mac_reg;
    logic [31:0] loss_timeout_reg;

    state_t state_reg, state_next;
    item_t  item_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] act_reg, act_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;   // address issued
    logic [CNT_W-1:0] ck_idx_reg, ck_idx_next;   // address of data in rd_reg
    logic             ck_vld_reg, ck_vld_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic             found_reg, found_next;
    entry_t           hit_reg, hit_next;

    logic             we;
    logic [SLOT_W-1:0] waddr;
    entry_t           wdata;
    logic             res_v;
    result_t          res;
    logic             res_v_reg;
    result_t          res_reg;

    logic [31:0] age;
    logic        due;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_mac_reg     <= '0;
            loss_timeout_reg <= 32'd10000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SELF_MAC:     self_mac_reg <= cfg_data;
                CFG_LOSS_TIMEOUT: loss_timeout_reg <= cfg_data[31:0];
                default:          ;
            endcase
        end
    end

    // synchronous memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[rd_idx_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            act_reg    <= '0;
            rd_idx_reg <= '0;
            ck_idx_reg <= '0;
            ck_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            res_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            act_reg    <= act_next;
            rd_idx_reg <= rd_idx_next;
            ck_idx_reg <= ck_idx_next;
            ck_vld_reg <= ck_vld_next;
            found_reg  <= found_next;
            res_v_reg  <= res_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
        slot_reg <= slot_next;
        hit_reg  <= hit_next;
        res_reg  <= res;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_v_reg;
    assign result       = res_reg;

    assign age = item_reg.now_ms - rd_reg.seen;
    assign due = ((rd_reg.status == ST_ACTIVE) || (rd_reg.status == ST_UNKNOWN))
                 && (age > loss_timeout_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (item.mode)
                        state_next = S_SWEEP;
                    else if (item.sender_mac != self_mac_reg)
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((ck_vld_reg && rd_reg.mac == item_reg.src_mac) ||
                    (ck_idx_reg >= count_reg))
                    state_next = S_WRITE;
            end
            S_WRITE:  state_next = S_IDLE;
            S_SWEEP:
            begin
                if (ck_idx_reg >= count_reg)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic [1:0]  st_new;
        logic [2:0]  ev;
        logic [CNT_W-1:0] act_new;
        entry_t      e;
        count_next  = count_reg;
        act_next    = act_reg;
        rd_idx_next = rd_idx_reg;
        ck_idx_next = ck_idx_reg;
        ck_vld_next = ck_vld_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        hit_next    = hit_reg;
        we          = 1'b0;
        waddr       = slot_reg;
        wdata       = rd_reg;
        res_v       = 1'b0;
        res         = '0;
        st_new      = ST_UNKNOWN;
        ev          = EV_UPDATED;
        act_new     = act_reg;
        e           = hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                rd_idx_next = '0;
                ck_idx_next = '0;
                ck_vld_next = 1'b0;
                found_next  = 1'b0;
                if (start)
                begin
                    if (!item.mode && item.sender_mac == self_mac_reg)
                    begin
                        res_v            = 1'b1;
                        res.event_res    = EV_OWN;
                        res.node_mac     = item.sender_mac;
                        res.active_count = act_reg;
                        res.last         = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = CNT_W'(1);
                        ck_vld_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
                ck_idx_next = ck_idx_reg + CNT_W'(1);
                slot_next   = ck_idx_reg[SLOT_W-1:0];
                if (ck_vld_reg && ck_idx_reg < count_reg &&
                    rd_reg.mac == item_reg.src_mac)
                begin
                    found_next = 1'b1;
                    hit_next   = rd_reg;
                end
                else if (ck_idx_reg >= count_reg)
                begin
                    slot_next = count_reg[SLOT_W-1:0];
                    hit_next.mac    = item_reg.src_mac;
                    hit_next.status = ST_UNKNOWN;
                    hit_next.rep    = '0;
                end
            end
            S_WRITE:
            begin
                // next item's first read must address entry 0
                rd_idx_next = '0;
                if (!found_reg && count_reg >= CNT_W'(MAX_PEERS))
                begin
                    res_v            = 1'b1;
                    res.event_res    = EV_FULL;
                    res.node_mac     = item_reg.src_mac;
                    res.active_count = act_reg;
                    res.last         = 1'b1;
                end
                else
                begin
                    if (!found_reg)
                        count_next = count_reg + CNT_W'(1);
                    e.seen = item_reg.now_ms;
                    e.rssi = item_reg.rssi;
                    st_new = hit_reg.status;
                    if ((item_reg.packet_type == PT_HEARTBEAT ||
                         item_reg.packet_type == PT_DISCOVERY) && item_reg.payload_ok)
                    begin
                        if (item_reg.packet_type == PT_HEARTBEAT)
                            e.rep = item_reg.reported_neighbours;
                        if (hit_reg.status == ST_LOST || hit_reg.status == ST_UNKNOWN)
                            ev = EV_JOINED;
                        st_new = ST_ACTIVE;
                    end
                    else if (item_reg.packet_type == PT_SLEEP)
                        st_new = ST_SLEEP;
                    else if (item_reg.packet_type == PT_WAKE)
                        st_new = ST_ACTIVE;
                    e.status = st_new;
                    act_new = act_reg - CNT_W'(hit_reg.status == ST_ACTIVE)
                              + CNT_W'(st_new == ST_ACTIVE);
                    act_next = act_new;
                    we       = 1'b1;
                    waddr    = slot_reg;
                    wdata    = e;
                    res_v            = 1'b1;
                    res.event_res    = ev;
                    res.slot         = 4'(slot_reg);
                    res.node_mac     = e.mac;
                    res.active_count = act_new;
                    res.last         = 1'b1;
                end
            end
            S_SWEEP:
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
                ck_idx_next = ck_idx_reg + CNT_W'(1);
                if (ck_idx_reg < count_reg)
                begin
                    if (due)
                    begin
                        act_new = act_reg - CNT_W'(rd_reg.status == ST_ACTIVE);
                        act_next = act_new;
                        we       = 1'b1;
                        waddr    = ck_idx_reg[SLOT_W-1:0];
                        wdata    = rd_reg;
                        wdata.status = ST_LOST;
                        res_v            = 1'b1;
                        res.event_res    = EV_LOST;
                        res.slot         = 4'(ck_idx_reg[SLOT_W-1:0]);
                        res.node_mac     = rd_reg.mac;
                        res.active_count = act_new;
                    end
                end
                else
                begin
                    rd_idx_next      = '0;
                    res_v            = 1'b1;
                    res.event_res    = EV_DONE;
                    res.active_count = act_reg;
                    res.last         = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule
